// ===== rtl/dmht_pkg.sv =====
package dmht_pkg;

  // Table geometry
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned SLOT_COUNT = 1 << INDEX_BITS;

  // Clear generation stamped into every written slot; zero is never live
  localparam int unsigned EPOCH_BITS = 8;

  localparam logic [1:0]        BOUND_EXACT = 2'd2;
  localparam logic signed [7:0] MISS_DEPTH  = -8'sd1;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_PROBE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CHECK
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [63:0]        key;
    logic signed [7:0]  search_depth;
    logic signed [15:0] eval_score;
    logic [1:0]         bound_type;
    logic [15:0]        move_code;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic                  written;
    logic signed [15:0]    found_score;
    logic signed [7:0]     found_depth;
    logic [1:0]            found_bound;
    logic [15:0]           found_move;
  } rsp_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [63:0]           key;
    logic signed [15:0]    score;
    logic signed [7:0]     depth;
    logic [1:0]            bound;
    logic [15:0]           move;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic check;
    logic sweep_wr;
    logic sweep_end;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;
    logic sweep_last;
    logic epoch_full;
    logic op_clear;
  } status_t;

endpackage

// ===== rtl/dmht_req_if.sv =====
interface dmht_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [63:0]        key;
  logic signed [7:0]  search_depth;
  logic signed [15:0] eval_score;
  logic [1:0]         bound_type;
  logic [15:0]        move_code;

  modport source (
    output valid, kind, key, search_depth, eval_score, bound_type, move_code,
    input  ready
  );

  modport sink (
    input  valid, kind, key, search_depth, eval_score, bound_type, move_code,
    output ready
  );
endinterface

// ===== rtl/dmht_rsp_if.sv =====
interface dmht_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               written;
  logic signed [15:0] found_score;
  logic signed [7:0]  found_depth;
  logic [1:0]         found_bound;
  logic [15:0]        found_move;

  modport source (
    output valid, hit, written, found_score, found_depth, found_bound, found_move,
    input  ready
  );

  modport sink (
    input  valid, hit, written, found_score, found_depth, found_bound, found_move,
    output ready
  );
endinterface

// ===== rtl/direct_mapped_hash_table_unit.sv =====
// Channel | Dir | Handshake   | Payload
// req_i   | in  | valid/ready | kind, key, search_depth, eval_score, bound_type, move_code
// rsp_o   | out | valid/ready | hit, written, found_score, found_depth, found_bound, found_move
//
// Each item passes through two states: the slot is read from the table RAM in IDLE, then
// CHECK compares/writes and loads the result register. A new request waits for IDLE.
// After reset a clearing pass over all 1024 slots (one slot per cycle) runs before req_i is ready.
// Clear bumps an 8-bit generation stamp; every 255th clear adds the same clearing pass.
// Stalls: a result waits in the output register; a new transfer is taken once it is free
// or being taken in the same cycle.
module direct_mapped_hash_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  dmht_req_if.sink       req_i,
  dmht_rsp_if.source     rsp_o
);

  dmht_pkg::req_t    req;
  dmht_pkg::rsp_t    rsp;
  dmht_pkg::cmd_t    cmd;
  dmht_pkg::status_t status;
  logic              req_ready;
  logic              rsp_valid;

  // Pack the request transfer for the datapath
  assign req.kind         = dmht_pkg::kind_e'(req_i.kind);
  assign req.key          = req_i.key;
  assign req.search_depth = req_i.search_depth;
  assign req.eval_score   = req_i.eval_score;
  assign req.bound_type   = req_i.bound_type;
  assign req.move_code    = req_i.move_code;

  dmht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .status_i    (status),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  // Table RAM, generation stamps, sweep counter and result register
  dmht_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_ready_i (rsp_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid)
  );

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.written     = rsp.written;
  assign rsp_o.found_score = rsp.found_score;
  assign rsp_o.found_depth = rsp.found_depth;
  assign rsp_o.found_bound = rsp.found_bound;
  assign rsp_o.found_move  = rsp.found_move;

endmodule

// ===== rtl/dmht_ctrl.sv =====
module dmht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  dmht_pkg::status_t  status_i,
  output logic               req_ready_o,
  output dmht_pkg::cmd_t     cmd_o
);

  dmht_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmht_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmht_pkg::ST_IDLE: begin
        if (req_valid_i && status_i.out_free) begin
          state_d = dmht_pkg::ST_CHECK;
        end
      end
      dmht_pkg::ST_CHECK: begin
        if (status_i.op_clear && status_i.epoch_full) begin
          state_d = dmht_pkg::ST_SWEEP;
        end else begin
          state_d = dmht_pkg::ST_IDLE;
        end
      end
      dmht_pkg::ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = dmht_pkg::ST_IDLE;
        end
      end
      default: state_d = dmht_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      dmht_pkg::ST_IDLE: begin
        req_ready_o  = status_i.out_free;
        cmd_o.accept = req_valid_i && status_i.out_free;
      end
      dmht_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      dmht_pkg::ST_SWEEP: begin
        cmd_o.sweep_wr  = 1'b1;
        cmd_o.sweep_end = status_i.sweep_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/dmht_datapath.sv =====
module dmht_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmht_pkg::req_t     req_i,
  input  logic               rsp_ready_i,
  input  dmht_pkg::cmd_t     cmd_i,
  output dmht_pkg::status_t  status_o,
  output dmht_pkg::rsp_t     rsp_o,
  output logic               rsp_valid_o
);

  dmht_pkg::entry_t mem_q [dmht_pkg::SLOT_COUNT];
  dmht_pkg::entry_t rd_q;
  dmht_pkg::req_t   op_q;

  logic [dmht_pkg::EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic [dmht_pkg::INDEX_BITS-1:0] sweep_q, sweep_d;
  logic [dmht_pkg::INDEX_BITS-1:0] rd_idx, op_idx, wr_idx;

  logic             wr_en;
  dmht_pkg::entry_t wr_data;

  logic key_live, slot_live, key_match, deeper, replace, hit;

  dmht_pkg::rsp_t rsp_q, rsp_d;
  logic           rsp_valid_q, rsp_valid_d;

  assign rd_idx = req_i.key[dmht_pkg::INDEX_BITS-1:0];
  assign op_idx = op_q.key[dmht_pkg::INDEX_BITS-1:0];

  // Slot is live only if stamped with the current clear generation
  always_comb begin
    key_live  = op_q.key != 64'd0;
    slot_live = rd_q.tag == epoch_q;
    key_match = slot_live && (rd_q.key == op_q.key);
    deeper    = slot_live && ($signed(op_q.search_depth) > $signed(rd_q.depth));
    replace   = (op_q.kind == dmht_pkg::KIND_STORE) && key_live &&
                (!slot_live || key_match || deeper ||
                 (op_q.bound_type == dmht_pkg::BOUND_EXACT));
    hit       = (op_q.kind == dmht_pkg::KIND_PROBE) && key_live && key_match;
  end

  always_comb begin
    rsp_d             = rsp_q;
    if (cmd_i.check) begin
      rsp_d.hit         = hit;
      rsp_d.written     = replace;
      rsp_d.found_score = hit ? rd_q.score : 16'sd0;
      rsp_d.found_depth = hit ? rd_q.depth : dmht_pkg::MISS_DEPTH;
      rsp_d.found_bound = hit ? rd_q.bound : 2'd0;
      rsp_d.found_move  = hit ? rd_q.move  : 16'd0;
    end
  end

  always_comb begin
    if (cmd_i.check) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // Single write port: sweep has priority (never overlaps a check)
  always_comb begin
    if (cmd_i.sweep_wr) begin
      wr_en   = 1'b1;
      wr_idx  = sweep_q;
      wr_data = '0;
    end else begin
      wr_en         = cmd_i.check && replace;
      wr_idx        = op_idx;
      wr_data.tag   = epoch_q;
      wr_data.key   = op_q.key;
      wr_data.score = op_q.eval_score;
      wr_data.depth = op_q.search_depth;
      wr_data.bound = op_q.bound_type;
      wr_data.move  = op_q.move_code;
    end
  end

  always_comb begin
    epoch_d = epoch_q;
    if (cmd_i.sweep_end) begin
      epoch_d = dmht_pkg::EPOCH_BITS'(1);
    end else if (cmd_i.check && (op_q.kind == dmht_pkg::KIND_CLEAR) && !(&epoch_q)) begin
      epoch_d = epoch_q + dmht_pkg::EPOCH_BITS'(1);
    end
  end

  assign sweep_d = cmd_i.sweep_wr ? sweep_q + dmht_pkg::INDEX_BITS'(1) : sweep_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= '0;
      sweep_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign status_o.out_free   = !rsp_valid_q || rsp_ready_i;
  assign status_o.sweep_last = &sweep_q;
  assign status_o.epoch_full = &epoch_q;
  assign status_o.op_clear   = op_q.kind == dmht_pkg::KIND_CLEAR;

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== rtl/dmht_checker.sv =====
module dmht_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               rsp_hit_i,
  input logic               rsp_written_i,
  input logic signed [15:0] rsp_found_score_i,
  input logic signed [7:0]  rsp_found_depth_i,
  input logic [1:0]         rsp_found_bound_i,
  input logic [15:0]        rsp_found_move_i
);

  // Result waiting for a taker stays valid with hit, written, score and move held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i) &&
    $stable(rsp_written_i) && $stable(rsp_found_score_i) && $stable(rsp_found_move_i))
    else $error("result dropped or changed while stalled");

  // Request transfer -> busy next cycle, result shown the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i ##1 rsp_valid_i)
    else $error("request not followed by a result two cycles on");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_written_i))
    else $error("hit and written both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_found_score_i == 16'sd0 &&
    rsp_found_depth_i == -8'sd1 && rsp_found_bound_i == 2'd0 && rsp_found_move_i == 16'd0)
    else $error("miss result without miss values");

  // Clearing pass after reset keeps requests out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("request taken before the table was cleared");

endmodule

bind direct_mapped_hash_table_unit dmht_sva u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_written_i     (rsp_o.written),
  .rsp_found_score_i (rsp_o.found_score),
  .rsp_found_depth_i (rsp_o.found_depth),
  .rsp_found_bound_i (rsp_o.found_bound),
  .rsp_found_move_i  (rsp_o.found_move)
);

// ===== tb/dmht_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels, keeps a shadow of the table and compares each response.
module dmht_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dmht_req_if  req_mon,
  dmht_rsp_if  rsp_mon,
  output int   mismatches,
  output int   outstanding,
  output int   hits_seen
);

  logic                  shadow_used  [dmht_pkg::SLOT_COUNT];
  logic [63:0]           shadow_key   [dmht_pkg::SLOT_COUNT];
  logic signed [15:0]    shadow_score [dmht_pkg::SLOT_COUNT];
  logic signed [7:0]     shadow_depth [dmht_pkg::SLOT_COUNT];
  logic [1:0]            shadow_bound [dmht_pkg::SLOT_COUNT];
  logic [15:0]           shadow_move  [dmht_pkg::SLOT_COUNT];

  dmht_pkg::rsp_t awaited_q[$];
  dmht_pkg::rsp_t oldest;

  // Applies one request to the shadow table and returns the response it should give
  function automatic dmht_pkg::rsp_t table_access(dmht_pkg::kind_e kind, logic [63:0] key,
                                        logic signed [7:0] depth, logic signed [15:0] score,
                                        logic [1:0] bound, logic [15:0] move);
    logic [dmht_pkg::INDEX_BITS-1:0] slot;
    logic                            replace;
    dmht_pkg::rsp_t                  r;
    slot          = key[dmht_pkg::INDEX_BITS-1:0];
    r             = '0;
    r.found_depth = dmht_pkg::MISS_DEPTH;
    case (kind)
      dmht_pkg::KIND_STORE: begin
        if (key != 64'd0) begin
          replace = !shadow_used[slot] || shadow_key[slot] == key ||
                    depth > shadow_depth[slot] || bound == dmht_pkg::BOUND_EXACT;
          if (replace) begin
            shadow_used[slot]  = 1'b1;
            shadow_key[slot]   = key;
            shadow_score[slot] = score;
            shadow_depth[slot] = depth;
            shadow_bound[slot] = bound;
            shadow_move[slot]  = move;
            r.written          = 1'b1;
          end
        end
      end
      dmht_pkg::KIND_PROBE: begin
        if (key != 64'd0 && shadow_used[slot] && shadow_key[slot] == key) begin
          r.hit         = 1'b1;
          r.found_score = shadow_score[slot];
          r.found_depth = shadow_depth[slot];
          r.found_bound = shadow_bound[slot];
          r.found_move  = shadow_move[slot];
        end
      end
      dmht_pkg::KIND_CLEAR: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_used[i]) begin
        shadow_used[i]  = 1'b0;
        shadow_key[i]   = '0;
        shadow_score[i] = '0;
        shadow_depth[i] = '0;
        shadow_bound[i] = '0;
        shadow_move[i]  = '0;
      end
      awaited_q.delete();
      mismatches  = 0;
      outstanding = 0;
      hits_seen   = 0;
    end else begin
      // response first: a request taken at this edge cannot answer at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $error("response transfer with no request awaiting one");
          mismatches++;
        end else begin
          oldest = awaited_q.pop_front();
          check_field("hit", 32'(oldest.hit), 32'(rsp_mon.hit));
          check_field("written", 32'(oldest.written), 32'(rsp_mon.written));
          check_field("found_score", 32'(oldest.found_score), 32'(rsp_mon.found_score));
          check_field("found_depth", 32'(oldest.found_depth), 32'(rsp_mon.found_depth));
          check_field("found_bound", 32'(oldest.found_bound), 32'(rsp_mon.found_bound));
          check_field("found_move", 32'(oldest.found_move), 32'(rsp_mon.found_move));
          if (oldest.hit) hits_seen++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_q.push_back(table_access(dmht_pkg::kind_e'(req_mon.kind), req_mon.key,
                                         req_mon.search_depth, req_mon.eval_score,
                                         req_mon.bound_type, req_mon.move_code));
      end
      outstanding = awaited_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the direct-mapped hash table.
// A directed opening walks the replacement rules and the key-zero cases, then a
// random run hammers a few hot slots so that collisions, depth contests and
// repeat keys are common. A block of mostly clears in the middle takes the
// clear generation stamp past its wrap, which triggers the long clearing pass.
module tb_top;

  // Two keys sharing slot 5, differing in the upper bits
  localparam logic [63:0] KEY_A    = 64'h0123_4567_89AB_C005;
  localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_3005;
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_MSB  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_S0   = 64'h0000_0000_0000_0400;  // slot 0, non-zero key

  localparam int RANDOM_ITEMS = 1450;
  localparam int CLEAR_BURST_LO = 400;   // heavy-clear window, in random item numbers
  localparam int CLEAR_BURST_HI = 740;
  localparam int QUIET_TAIL = 1250;      // no idling from here on

  logic clk_i;
  logic rst_ni;

  logic              gaps_on;      // shared by both sides
  int unsigned       stall_left;
  int                fault_count;
  int                in_flight;
  int                probe_hits;
  int                n_store, n_probe, n_clear, n_nop;

  logic [63:0]                      recent_keys[$];
  logic [63-dmht_pkg::INDEX_BITS:0] hot_hi[4];
  logic [dmht_pkg::INDEX_BITS-1:0]  hot_idx[8];

  dmht_req_if req_if();
  dmht_rsp_if rsp_if();

  direct_mapped_hash_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  dmht_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .mismatches  (fault_count),
    .outstanding (in_flight),
    .hits_seen   (probe_hits)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Response side: ready drops in random bursts while gaps are on
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // One request transfer; called at a falling edge, returns at a falling edge.
  // valid stays high between back-to-back transfers.
  task automatic issue(dmht_pkg::kind_e kind, logic [63:0] key, logic signed [7:0] depth,
                       logic signed [15:0] score, logic [1:0] bound, logic [15:0] move);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req_if.kind         <= kind;
    req_if.key          <= key;
    req_if.search_depth <= depth;
    req_if.eval_score   <= score;
    req_if.bound_type   <= bound;
    req_if.move_code    <= move;
    req_if.valid        <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
    case (kind)
      dmht_pkg::KIND_STORE: n_store++;
      dmht_pkg::KIND_PROBE: n_probe++;
      dmht_pkg::KIND_CLEAR: n_clear++;
      default:              n_nop++;
    endcase
    if (kind == dmht_pkg::KIND_STORE && key != 64'd0) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
  endtask

  initial begin
    dmht_pkg::kind_e   kind;
    logic [63:0]       key;
    logic signed [7:0] depth;
    int unsigned       pick;

    rst_ni              = 1'b0;
    gaps_on             = 1'b1;
    n_store             = 0;
    n_probe             = 0;
    n_clear             = 0;
    n_nop               = 0;
    req_if.valid        = 1'b0;
    req_if.kind         = dmht_pkg::KIND_NOP;
    req_if.key          = '0;
    req_if.search_depth = '0;
    req_if.eval_score   = '0;
    req_if.bound_type   = '0;
    req_if.move_code    = '0;

    foreach (hot_hi[j]) begin
      key       = {$urandom, $urandom};
      hot_hi[j] = key[63:dmht_pkg::INDEX_BITS];
    end
    foreach (hot_idx[j]) begin
      key        = {$urandom, $urandom};
      hot_idx[j] = key[dmht_pkg::INDEX_BITS-1:0];
    end
    hot_idx[0] = '0;
    hot_idx[1] = '1;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: empty table, key zero, replacement rules ---
    issue(dmht_pkg::KIND_PROBE, 64'd0, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_STORE, 64'd0, 8'sd5, 16'sd7, 2'd2, 16'h1234);   // key zero: no write
    issue(dmht_pkg::KIND_PROBE, KEY_A, 8'sd0, 16'sd0, 2'd0, 16'd0);      // empty slot
    issue(dmht_pkg::KIND_STORE, KEY_A, 8'sd0, 16'sd100, 2'd0, 16'h00A1); // empty slot: write
    issue(dmht_pkg::KIND_PROBE, KEY_A, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_STORE, KEY_B, 8'sd0, 16'sd200, 2'd1, 16'h00B1); // equal depth: kept
    issue(dmht_pkg::KIND_STORE, KEY_B, 8'sd1, 16'sd201, 2'd1, 16'h00B2); // deeper: replaced
    issue(dmht_pkg::KIND_PROBE, KEY_A, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_PROBE, KEY_B, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_STORE, KEY_A, -8'sd128, -16'sd5, dmht_pkg::BOUND_EXACT,
          16'h00A2);                                                      // exact wins
    issue(dmht_pkg::KIND_STORE, KEY_A, -8'sd128, -16'sd6, 2'd0, 16'h00A3); // same key wins
    issue(dmht_pkg::KIND_STORE, KEY_B, 8'sd127, 16'sd300, 2'd3, 16'h00B3); // deeper: replaced, bound three
    issue(dmht_pkg::KIND_STORE, KEY_A, 8'sd127, 16'sd301, 2'd3, 16'h00A4); // tie, not exact
    issue(dmht_pkg::KIND_PROBE, KEY_B, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_STORE, KEY_ONES, -8'sd128, -16'sd32768, 2'd3, 16'hFFFF);
    issue(dmht_pkg::KIND_PROBE, KEY_ONES, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_STORE, KEY_MSB, 8'sd127, 16'sd32767, 2'd0, 16'h0000);
    issue(dmht_pkg::KIND_PROBE, KEY_MSB, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_NOP, KEY_MSB, 8'sd3, 16'sd3, 2'd2, 16'h5555);
    issue(dmht_pkg::KIND_CLEAR, 64'd0, 8'sd0, 16'sd0, 2'd0, 16'd0);
    issue(dmht_pkg::KIND_PROBE, KEY_B, 8'sd0, 16'sd0, 2'd0, 16'd0);      // gone after clear
    issue(dmht_pkg::KIND_STORE, KEY_B, -8'sd128, 16'sd1, 2'd0, 16'h00B4); // empty again: write
    issue(dmht_pkg::KIND_STORE, KEY_S0, 8'sd10, 16'sd9, 2'd1, 16'hAAAA);
    issue(dmht_pkg::KIND_PROBE, 64'd0, 8'sd0, 16'sd0, 2'd0, 16'd0);      // slot 0 valid, miss
    issue(dmht_pkg::KIND_STORE, 64'd0, 8'sd127, 16'sd0, dmht_pkg::BOUND_EXACT,
          16'd0);                                                         // slot 0 untouched
    issue(dmht_pkg::KIND_PROBE, KEY_S0, 8'sd0, 16'sd0, 2'd0, 16'd0);

    // --- random: hot slots and recent keys for collisions and hits ---
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = (i < QUIET_TAIL) && ((i / 90) % 4 != 3);

      pick = $urandom_range(0, 99);
      if (i >= CLEAR_BURST_LO && i < CLEAR_BURST_HI) begin
        kind = (pick < 85) ? dmht_pkg::KIND_CLEAR :
               (pick < 93) ? dmht_pkg::KIND_STORE : dmht_pkg::KIND_PROBE;
      end else begin
        kind = (pick < 3) ? dmht_pkg::KIND_CLEAR : (pick < 5) ? dmht_pkg::KIND_NOP :
               (pick < 50) ? dmht_pkg::KIND_STORE : dmht_pkg::KIND_PROBE;
      end

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        key = 64'd0;
      end else if (pick < 12) begin
        key = {$urandom, $urandom};
      end else if (pick < 60 && recent_keys.size() != 0) begin
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else begin
        key = {hot_hi[$urandom_range(0, 3)], hot_idx[$urandom_range(0, 7)]};
      end

      // half the depths near zero so ties and near misses are common
      if ($urandom_range(0, 1) == 0) depth = 8'($urandom_range(0, 8) - 4);
      else depth = 8'($urandom);

      issue(kind, key, depth, 16'($urandom), 2'($urandom), 16'($urandom));
    end
    req_if.valid <= 1'b0;

    wait (in_flight == 0);
    repeat (8) @(negedge clk_i);

    $display("summary: %0d stores, %0d probes (%0d hits), %0d clears, %0d no-ops",
             n_store, n_probe, probe_hits, n_clear, n_nop);
    $display("summary: clear count runs past the stamp wrap; idling on both channels");
    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog set well above the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
